// ----- hw/rtl/nhpst_pkg.sv -----
// Shared types and constants for the neo-Hookean plane-strain tangent block.
// Used by every module under hw/rtl; depends on nothing.
package nhpst_pkg;

  localparam int unsigned FRAC_BITS_DEF = 28;
  localparam int unsigned IN_FRAC       = 28;
  localparam int unsigned NPROD         = 6;
  localparam int unsigned QDEPTH        = 4;
  localparam int unsigned LOG_ROUNDS    = 32;

  localparam logic [31:0]        LN2_Q32 = 32'd2977044472;
  localparam logic signed [31:0] ONE_Q   = 32'(1 << IN_FRAC);

  localparam int unsigned P_XX = 0;
  localparam int unsigned P_XY = 1;
  localparam int unsigned P_XS = 2;
  localparam int unsigned P_YY = 3;
  localparam int unsigned P_YS = 4;
  localparam int unsigned P_SS = 5;

  localparam logic [1:0] CFG_LAMBDA = 2'd0;
  localparam logic [1:0] CFG_MU     = 2'd1;

  typedef struct packed {
    logic                   bad;
    logic [4:0]             k;
    logic [30:0]            mant;
    logic [NPROD-1:0][63:0] prod;
  } nh_item_t;

  typedef struct packed {
    logic                   bad;
    logic signed [37:0]     ln;
    logic [NPROD-1:0][63:0] prod;
  } nh_ln_t;

  // First of the two products summed into the m-weighted term of entry e.
  // The second one is the same product, except in the last entry, where it
  // is the shear component squared.
  function automatic int unsigned s_index(input int unsigned e);
    int unsigned r;
    case (e)
      0: r = P_XX;
      1: r = P_SS;
      5: r = P_XY;
      default: r = e;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/nhpst_front.sv -----
// Front end: accepts items, applies the spatial form, forms the tensor products
// and normalizes det F. Depends on nhpst_pkg.
module nhpst_front
  import nhpst_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               spatial_form,
  input  logic signed [31:0] cinv_xx,
  input  logic signed [31:0] cinv_yy,
  input  logic signed [31:0] cinv_xy,
  input  logic [31:0]        jacobian_det,
  input  logic               credit_ret,
  output logic               item_valid,
  output nh_item_t           item
);

  localparam int unsigned CW = $clog2(QDEPTH + 1);

  logic [CW-1:0]      credit_r, credit_nxt;
  logic               accept;
  logic signed [31:0] cx, cy, cs;
  logic [4:0]         lead;
  logic [31:0]        norm;
  logic signed [63:0] pr [NPROD];
  nh_item_t           item_nxt;
  logic               valid_r;
  nh_item_t           item_r;

  assign busy   = (credit_r == '0);
  assign accept = start && !busy;

  always_comb begin
    credit_nxt = credit_r;
    if (accept && !credit_ret) begin
      credit_nxt = credit_r - 1'b1;
    end else if (!accept && credit_ret) begin
      credit_nxt = credit_r + 1'b1;
    end
  end

  always_comb begin
    if (spatial_form) begin
      cx = ONE_Q;
      cy = ONE_Q;
      cs = '0;
    end else begin
      cx = cinv_xx;
      cy = cinv_yy;
      cs = cinv_xy;
    end
    lead = '0;
    for (int i = 1; i < 32; i++) begin
      if (jacobian_det[i]) begin
        lead = 5'(i);
      end
    end
    norm     = jacobian_det << (5'd31 - lead);
    pr[P_XX] = 64'(cx) * 64'(cx);
    pr[P_XY] = 64'(cx) * 64'(cy);
    pr[P_XS] = 64'(cx) * 64'(cs);
    pr[P_YY] = 64'(cy) * 64'(cy);
    pr[P_YS] = 64'(cy) * 64'(cs);
    pr[P_SS] = 64'(cs) * 64'(cs);
    item_nxt.bad  = (jacobian_det == '0);
    item_nxt.k    = lead;
    item_nxt.mant = norm[31:1];
    for (int j = 0; j < NPROD; j++) begin
      item_nxt.prod[j] = pr[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= CW'(QDEPTH);
      valid_r  <= 1'b0;
    end else begin
      credit_r <= credit_nxt;
      valid_r  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- hw/rtl/nhpst_queue.sv -----
// Short queue between front end and logarithm; it pops whenever not empty.
// Depends on nhpst_pkg.
module nhpst_queue
  import nhpst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  input  nh_item_t wr_item,
  output logic     pop,
  output logic     rd_valid,
  output nh_item_t rd_item
);

  localparam int unsigned AW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  nh_item_t      mem [QDEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          rd_valid_r;
  nh_item_t      rd_item_r;

  assign pop = (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    if (wr_valid && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_valid && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_valid) begin
        wr_ptr_r <= (wr_ptr_r == AW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r    <= count_nxt;
      rd_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      mem[wr_ptr_r] <= wr_item;
    end
    if (pop) begin
      rd_item_r <= mem[rd_ptr_r];
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_item  = rd_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QDEPTH))
    else $error("queue count exceeds depth");

  a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> rd_valid_r)
    else $error("pop did not produce a read beat");

  a_write_held: assert property (@(posedge clk) disable iff (!rst_n)
    wr_valid |=> (count_r != '0))
    else $error("written beat lost from queue");

endmodule

// ----- hw/rtl/nhpst_log.sv -----
// Natural logarithm of det F in Q.32 by repeated squaring, one round per stage.
// Carries the tensor products alongside. Depends on nhpst_pkg.
module nhpst_log
  import nhpst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  nh_item_t in_item,
  output logic     out_valid,
  output nh_ln_t   out_item
);

  typedef struct packed {
    logic                   bad;
    logic [4:0]             k;
    logic [30:0]            mant;
    logic [31:0]            fr;
    logic [NPROD-1:0][63:0] prod;
  } sq_t;

  sq_t                    stg_r [LOG_ROUNDS+1];
  logic [LOG_ROUNDS:0]    vld_r;
  logic signed [6:0]      ks;
  logic signed [39:0]     ta;
  logic [63:0]            fm;
  logic signed [39:0]     ta_r;
  logic [31:0]            tb_r;
  logic                   l1_bad_r;
  logic [NPROD-1:0][63:0] l1_prod_r;
  logic [1:0]             lv_r;
  logic signed [40:0]     lnw;
  nh_ln_t                 out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      lv_r  <= '0;
    end else begin
      vld_r <= {vld_r[LOG_ROUNDS-1:0], in_valid};
      lv_r  <= {lv_r[0], vld_r[LOG_ROUNDS]};
    end
  end

  always_ff @(posedge clk) begin
    stg_r[0].bad  <= in_item.bad;
    stg_r[0].k    <= in_item.k;
    stg_r[0].mant <= in_item.mant;
    stg_r[0].fr   <= '0;
    stg_r[0].prod <= in_item.prod;
  end

  for (genvar i = 0; i < LOG_ROUNDS; i++) begin : g_round
    logic [61:0] sq;
    sq_t         nxt;

    always_comb begin
      nxt = stg_r[i];
      sq  = 62'(stg_r[i].mant) * 62'(stg_r[i].mant);
      if (sq[61]) begin
        nxt.mant = sq[61:31];
        nxt.fr   = {stg_r[i].fr[30:0], 1'b1};
      end else begin
        nxt.mant = sq[60:30];
        nxt.fr   = {stg_r[i].fr[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      stg_r[i+1] <= nxt;
    end
  end

  always_comb begin
    ks  = $signed({2'b00, stg_r[LOG_ROUNDS].k}) - 7'sd28;
    ta  = 40'(ks) * 40'($signed({1'b0, LN2_Q32}));
    fm  = 64'(stg_r[LOG_ROUNDS].fr) * 64'(LN2_Q32);
    lnw = 41'(ta_r) + 41'($signed({1'b0, tb_r}));
  end

  always_ff @(posedge clk) begin
    ta_r         <= ta;
    tb_r         <= fm[63:32];
    l1_bad_r     <= stg_r[LOG_ROUNDS].bad;
    l1_prod_r    <= stg_r[LOG_ROUNDS].prod;
    out_r.bad    <= l1_bad_r;
    out_r.ln     <= lnw[37:0];
    out_r.prod   <= l1_prod_r;
  end

  assign out_valid = lv_r[1];
  assign out_item  = out_r;

endmodule

// ----- hw/rtl/nhpst_back.sv -----
// Back end: forms m = mu - lambda*ln(det F) and the six tangent entries,
// then shifts and saturates them. Depends on nhpst_pkg.
module nhpst_back
  import nhpst_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        lame_lambda,
  input  logic [31:0]        lame_mu,
  input  logic               in_valid,
  input  nh_ln_t             in_item,
  output logic               strobe,
  output logic signed [63:0] d [NPROD],
  output logic               bad
);

  localparam int unsigned SHIFT = 88 - FRAC_BITS;
  localparam logic [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

  logic [7:0]             vld_r, bad_r;
  logic                   strobe_r, obad_r;
  logic signed [70:0]     lp_r;
  logic [NPROD-1:0][63:0] prod1_r;
  logic signed [71:0]     mw, mabs;
  logic                   mneg_r;
  logic [69:0]            mmag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      vld_r    <= {vld_r[6:0], in_valid};
      strobe_r <= vld_r[7];
    end
  end

  always_ff @(posedge clk) begin
    bad_r  <= {bad_r[6:0], in_item.bad};
    obad_r <= bad_r[7];
  end

  always_comb begin
    mw   = 72'($signed({1'b0, lame_mu, 32'd0})) - 72'(lp_r);
    mabs = mw[71] ? -mw : mw;
  end

  always_ff @(posedge clk) begin
    lp_r    <= 71'($signed({1'b0, lame_lambda})) * 71'(in_item.ln);
    prod1_r <= in_item.prod;
    mneg_r  <= mw[71];
    mmag_r  <= mabs[69:0];
  end

  for (genvar e = 0; e < NPROD; e++) begin : g_entry
    localparam int unsigned SI = s_index(e);
    localparam int unsigned SJ = (e == NPROD - 1) ? P_SS : SI;

    logic [63:0]        t1, sv, sabs;
    logic               sneg;
    logic               t1neg_r, sneg_r;
    logic [62:0]        t1mag_r;
    logic [63:0]        smag_r;
    logic [63:0]        p00_r, p10_r, p01_r, p11_r, c0_r;
    logic [37:0]        p20_r, p21_r;
    logic [62:0]        c1_r;
    logic [64:0]        mid_r, hi_r;
    logic [94:0]        wa2_r, wa3_r;
    logic [63:0]        p00b_r;
    logic [37:0]        p21b_r;
    logic [97:0]        x_r;
    logic [70:0]        y_r;
    logic [134:0]       wbm_r;
    logic [135:0]       was_r, was5_r, wbs_r, sum_r;
    logic [135:0]       wa_ex, wb_ex;
    logic [4:0]         wan_r, wbn_r;
    logic signed [135:0] shv;
    logic [63:0]        res;
    logic signed [63:0] d_r;

    always_comb begin
      t1    = prod1_r[e];
      sv    = prod1_r[SI] + prod1_r[SJ];
      sneg  = sv[63] && (sv != SAT_MIN);
      sabs  = sneg ? (~sv + 64'd1) : sv;
      wa_ex = 136'({wa3_r, 32'd0});
      wb_ex = 136'(wbm_r);
      shv   = $signed(sum_r) >>> SHIFT;
      if ((&shv[135:63]) || !(|shv[135:63])) begin
        res = shv[63:0];
      end else begin
        res = shv[135] ? SAT_MIN : SAT_MAX;
      end
    end

    always_ff @(posedge clk) begin
      t1neg_r  <= t1[63];
      t1mag_r  <= t1[63] ? 63'(~t1 + 64'd1) : t1[62:0];
      sneg_r   <= sneg;
      smag_r   <= sabs;
      p00_r    <= 64'(mmag_r[31:0]) * 64'(smag_r[31:0]);
      p10_r    <= 64'(mmag_r[63:32]) * 64'(smag_r[31:0]);
      p01_r    <= 64'(mmag_r[31:0]) * 64'(smag_r[63:32]);
      p11_r    <= 64'(mmag_r[63:32]) * 64'(smag_r[63:32]);
      p20_r    <= 38'(mmag_r[69:64]) * 38'(smag_r[31:0]);
      p21_r    <= 38'(mmag_r[69:64]) * 38'(smag_r[63:32]);
      c0_r     <= 64'(lame_lambda) * 64'(t1mag_r[31:0]);
      c1_r     <= 63'(lame_lambda) * 63'(t1mag_r[62:32]);
      wan_r    <= {wan_r[3:0], t1neg_r};
      wbn_r    <= {wbn_r[3:0], mneg_r ^ sneg_r};
      mid_r    <= 65'(p01_r) + 65'(p10_r);
      hi_r     <= 65'(p11_r) + 65'(p20_r);
      wa2_r    <= 95'(c0_r) + {c1_r, 32'd0};
      p00b_r   <= p00_r;
      p21b_r   <= p21_r;
      x_r      <= 98'(p00b_r) + 98'({mid_r, 32'd0});
      y_r      <= 71'(hi_r) + 71'({p21b_r, 32'd0});
      wa3_r    <= wa2_r;
      wbm_r    <= 135'(x_r) + {y_r, 64'd0};
      was_r    <= wan_r[2] ? (~wa_ex + 136'd1) : wa_ex;
      wbs_r    <= wbn_r[3] ? (~wb_ex + 136'd1) : wb_ex;
      was5_r   <= was_r;
      sum_r    <= was5_r + wbs_r;
      d_r      <= bad_r[7] ? '0 : $signed(res);
    end

    assign d[e] = d_r;
  end

  assign strobe = strobe_r;
  assign bad    = obad_r;

endmodule

// ----- hw/rtl/neo_hookean_plane_strain_tangent_top.sv -----
// Top level of the neo-Hookean plane-strain tangent block: configuration
// registers and the front end, queue, logarithm and back end chain.
// Depends on nhpst_pkg and the nhpst_* modules.
//
// Usage: write lame_lambda (index 0) and lame_mu (index 1) on the cfg_ channel
// while the block is idle; cfg_ready is always high. An item is accepted at a
// rising edge with start high and busy low. The block takes one item per
// cycle; busy rises only when the four-entry queue behind the front end has
// no free slot, which does not happen in steady streaming because the queue
// passes one beat on to the logarithm every cycle.
// Each result appears on the out_ ports for one cycle with out_strobe high,
// in accept order. Its path runs through the front end, the queue, the
// 32-round squaring pipeline of the logarithm and the wide multiply and
// saturation stages of the back end.
// The receiver cannot stall, so no result is held back. Synchronous reset
// clears both registers to zero and empties every pipeline and the queue.
module neo_hookean_plane_strain_tangent_top
  import nhpst_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_spatial_form,
  input  logic signed [31:0] in_cinv_xx,
  input  logic signed [31:0] in_cinv_yy,
  input  logic signed [31:0] in_cinv_xy,
  input  logic [31:0]        in_jacobian_det,
  output logic               out_strobe,
  output logic signed [63:0] out_d_xx_xx,
  output logic signed [63:0] out_d_xx_yy,
  output logic signed [63:0] out_d_xx_xy,
  output logic signed [63:0] out_d_yy_yy,
  output logic signed [63:0] out_d_yy_xy,
  output logic signed [63:0] out_d_xy_xy,
  output logic               out_bad_determinant,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [31:0]        lambda_r, mu_r;
  logic               credit_ret;
  logic               fe_valid, q_valid, ln_valid;
  nh_item_t           fe_item, q_item;
  nh_ln_t             ln_item;
  logic signed [63:0] d [NPROD];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lambda_r <= '0;
      mu_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LAMBDA: lambda_r <= cfg_data;
        CFG_MU:     mu_r     <= cfg_data;
        default:    lambda_r <= lambda_r;
      endcase
    end
  end

  nhpst_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .spatial_form (in_spatial_form),
    .cinv_xx      (in_cinv_xx),
    .cinv_yy      (in_cinv_yy),
    .cinv_xy      (in_cinv_xy),
    .jacobian_det (in_jacobian_det),
    .credit_ret   (credit_ret),
    .item_valid   (fe_valid),
    .item         (fe_item)
  );

  nhpst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fe_valid),
    .wr_item  (fe_item),
    .pop      (credit_ret),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  nhpst_log u_log (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .out_valid (ln_valid),
    .out_item  (ln_item)
  );

  nhpst_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .lame_lambda (lambda_r),
    .lame_mu     (mu_r),
    .in_valid    (ln_valid),
    .in_item     (ln_item),
    .strobe      (out_strobe),
    .d           (d),
    .bad         (out_bad_determinant)
  );

  assign out_d_xx_xx = d[0];
  assign out_d_xx_yy = d[1];
  assign out_d_xx_xy = d[2];
  assign out_d_yy_yy = d[3];
  assign out_d_yy_xy = d[4];
  assign out_d_xy_xy = d[5];

endmodule

// ----- test/neo_hookean_plane_strain_tangent_top_test.sv -----
// Self-checking testbench for neo_hookean_plane_strain_tangent_top: directed table plus
// random beats, each checked against an exact wide-integer tangent predictor or zeros.
// Depends on nhpst_pkg and the RTL under hw/rtl.
`timescale 1ns / 100ps

module neo_hookean_plane_strain_tangent_top_test
  import nhpst_pkg::*;
();

  localparam int unsigned FRAC_BITS = FRAC_BITS_DEF;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [63:0] xx_xx;
    logic signed [63:0] xx_yy;
    logic signed [63:0] xx_xy;
    logic signed [63:0] yy_yy;
    logic signed [63:0] yy_xy;
    logic signed [63:0] xy_xy;
    logic               bad;
  } tangent_t;

  typedef struct packed {
    logic               spatial;
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] xy;
    logic [31:0]        det;
  } point_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_spatial_form;
  logic signed [31:0] in_cinv_xx, in_cinv_yy, in_cinv_xy;
  logic [31:0] in_jacobian_det;
  logic out_strobe;
  logic signed [63:0] out_d_xx_xx, out_d_xx_yy, out_d_xx_xy;
  logic signed [63:0] out_d_yy_yy, out_d_yy_xy, out_d_xy_xy;
  logic out_bad_determinant;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  logic [31:0] lambda_now;
  logic [31:0] mu_now;
  tangent_t    pending_tangents[$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          allow_gaps;

  neo_hookean_plane_strain_tangent_top #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_spatial_form(in_spatial_form), .in_cinv_xx(in_cinv_xx),
    .in_cinv_yy(in_cinv_yy), .in_cinv_xy(in_cinv_xy),
    .in_jacobian_det(in_jacobian_det),
    .out_strobe(out_strobe), .out_d_xx_xx(out_d_xx_xx), .out_d_xx_yy(out_d_xx_yy),
    .out_d_xx_xy(out_d_xx_xy), .out_d_yy_yy(out_d_yy_yy), .out_d_yy_xy(out_d_yy_xy),
    .out_d_xy_xy(out_d_xy_xy), .out_bad_determinant(out_bad_determinant),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [63:0] tangent_entry(logic signed [191:0] m,
      logic signed [191:0] lam, logic signed [191:0] t1, logic signed [191:0] s);
    logic signed [191:0] v;
    v = ((lam * t1) <<< 32) + m * s;
    v = v >>> (88 - FRAC_BITS);
    if (v > 192'sh7FFFFFFFFFFFFFFF) return 64'sh7FFFFFFFFFFFFFFF;
    if (v < -192'sh8000000000000000) return 64'sh8000000000000000;
    return v[63:0];
  endfunction

  function automatic tangent_t predict_tangent(point_t p);
    tangent_t r;
    logic signed [191:0] cx, cy, cs, lam, m, ln;
    logic [63:0] mant, fr;
    int k;
    r = '0;
    if (p.det == 0) begin
      r.bad = 1'b1;
      return r;
    end
    if (p.spatial) begin
      cx = 192'sd1 <<< IN_FRAC;
      cy = cx;
      cs = 0;
    end else begin
      cx = p.xx;
      cy = p.yy;
      cs = p.xy;
    end
    k = 31;
    while (k > 0 && !p.det[k]) k--;
    mant = (k <= 30) ? ({32'b0, p.det} << (30 - k)) : ({32'b0, p.det} >> (k - 30));
    fr = 0;
    for (int i = 0; i < LOG_ROUNDS; i++) begin
      mant = (mant * mant) >> 30;
      fr = fr << 1;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        fr[0] = 1'b1;
      end
    end
    ln = $signed(192'(k - int'(IN_FRAC))) * $signed({160'b0, LN2_Q32})
       + $signed({128'b0, (fr * {32'b0, LN2_Q32}) >> 32});
    lam = $signed({160'b0, lambda_now});
    m = ($signed({160'b0, mu_now}) <<< 32) - lam * ln;
    r.xx_xx = tangent_entry(m, lam, cx * cx, 2 * cx * cx);
    r.xx_yy = tangent_entry(m, lam, cx * cy, 2 * cs * cs);
    r.xx_xy = tangent_entry(m, lam, cx * cs, 2 * cx * cs);
    r.yy_yy = tangent_entry(m, lam, cy * cy, 2 * cy * cy);
    r.yy_xy = tangent_entry(m, lam, cy * cs, 2 * cy * cs);
    r.xy_xy = tangent_entry(m, lam, cs * cs, cx * cy + cs * cs);
    return r;
  endfunction

  always @(posedge clk) begin
    tangent_t want;
    if (rst_n && out_strobe) begin
      if (pending_tangents.size() == 0) begin
        $error("result beat with no expectation waiting");
        error_count++;
      end else begin
        want = pending_tangents.pop_front();
        if (out_d_xx_xx !== want.xx_xx) begin
          $error("d_xx_xx expected %0d got %0d", want.xx_xx, out_d_xx_xx);
          error_count++;
        end
        if (out_d_xx_yy !== want.xx_yy) begin
          $error("d_xx_yy expected %0d got %0d", want.xx_yy, out_d_xx_yy);
          error_count++;
        end
        if (out_d_xx_xy !== want.xx_xy) begin
          $error("d_xx_xy expected %0d got %0d", want.xx_xy, out_d_xx_xy);
          error_count++;
        end
        if (out_d_yy_yy !== want.yy_yy) begin
          $error("d_yy_yy expected %0d got %0d", want.yy_yy, out_d_yy_yy);
          error_count++;
        end
        if (out_d_yy_xy !== want.yy_xy) begin
          $error("d_yy_xy expected %0d got %0d", want.yy_xy, out_d_yy_xy);
          error_count++;
        end
        if (out_d_xy_xy !== want.xy_xy) begin
          $error("d_xy_xy expected %0d got %0d", want.xy_xy, out_d_xy_xy);
          error_count++;
        end
        if (out_bad_determinant !== want.bad) begin
          $error("bad_determinant expected %0d got %0d", want.bad, out_bad_determinant);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[neo_hookean_plane_strain_tangent_top] ERROR");
      $finish;
    end
  end

  // Leaves cfg_valid high; the caller drops it after its last write.
  task automatic write_register(logic [1:0] index, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == CFG_LAMBDA) lambda_now = value;
    else if (index == CFG_MU) mu_now = value;
  endtask

  task automatic set_moduli(logic [31:0] lam, logic [31:0] mu);
    write_register(CFG_LAMBDA, lam);
    write_register(CFG_MU, mu);
    cfg_valid <= 1'b0;
  endtask

  // Beat is driven now and accepted at the first later edge with busy low.
  task automatic send_point(point_t p, bit typed, tangent_t typed_result);
    start <= 1'b1;
    in_spatial_form <= p.spatial;
    in_cinv_xx <= p.xx;
    in_cinv_yy <= p.yy;
    in_cinv_xy <= p.xy;
    in_jacobian_det <= p.det;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_tangents.insert(pending_tangents.size(),
                            typed ? typed_result : predict_tangent(p));
    if (allow_gaps && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_tangents.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_det();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return $urandom_range(1, 255);
      2: return 32'hFFFFFFFF - $urandom_range(255);
      3, 4, 5: return (32'd1 << IN_FRAC) + $urandom_range(0, 32'h00FFFFFF) - 32'h007FFFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_component();
    case ($urandom_range(5))
      0: return $urandom;
      1: return ($urandom_range(1)) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h3FFFFFFF)) - 32'sh1FFFFFFF;
    endcase
  endfunction

  task automatic run_random(int unsigned count);
    point_t p;
    for (int unsigned i = 0; i < count; i++) begin
      p.spatial = ($urandom_range(3) == 0);
      p.xx = pick_component();
      p.yy = pick_component();
      p.xy = pick_component();
      p.det = pick_det();
      send_point(p, 1'b0, '0);
    end
  endtask

  point_t   directed[] = '{
    '{1'b0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'h00000000},
    '{1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'h00000000},
    '{1'b0, 32'sh10000000, 32'sh10000000, 32'sh00000000, 32'h10000000},
    '{1'b1, 32'sh00000000, 32'sh00000000, 32'sh00000000, 32'h10000000},
    '{1'b0, 32'sh10000000, 32'sh08000000, 32'sh02000000, 32'h00000001},
    '{1'b0, 32'sh10000000, 32'sh08000000, 32'shFE000000, 32'hFFFFFFFF},
    '{1'b1, 32'sh12345678, 32'sh00000000, 32'sh00000000, 32'h00000001},
    '{1'b1, 32'sh00000000, 32'sh00000000, 32'sh00000000, 32'hFFFFFFFF},
    '{1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'h80000000},
    '{1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'h20000000},
    '{1'b0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh00000001, 32'h00000003},
    '{1'b0, 32'shF0000000, 32'sh10000000, 32'shF8000000, 32'h0C000000},
    '{1'b0, 32'sh00000000, 32'sh00000000, 32'sh00000000, 32'h40000000},
    '{1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'h7FFFFFFF}
  };

  task automatic run_directed(bit after_reset);
    tangent_t zero_result;
    foreach (directed[i]) begin
      zero_result = '0;
      zero_result.bad = (directed[i].det == 0);
      send_point(directed[i], after_reset || zero_result.bad, zero_result);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_spatial_form = 1'b0;
    in_cinv_xx = '0;
    in_cinv_yy = '0;
    in_cinv_xy = '0;
    in_jacobian_det = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LAMBDA;
    cfg_data = '0;
    lambda_now = '0;
    mu_now = '0;
    error_count = 0;
    cycle_count = 0;
    allow_gaps = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With both moduli at their reset value of zero every tangent is zero.
    run_directed(1'b1);
    wait_idle();
    set_moduli(32'hFFFFFFFF, 32'hFFFFFFFF);
    run_directed(1'b0);
    run_random(400);
    wait_idle();
    set_moduli(32'd0, $urandom);
    allow_gaps = 1'b0;
    run_random(400);
    allow_gaps = 1'b1;
    wait_idle();
    set_moduli($urandom, 32'd0);
    run_random(400);
    wait_idle();
    set_moduli($urandom_range(1, 1000), $urandom_range(1, 1000));
    run_random(400);
    wait_idle();

    if (error_count == 0) begin
      $display("[neo_hookean_plane_strain_tangent_top] OK");
    end else begin
      $display("[neo_hookean_plane_strain_tangent_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/nhpst_pkg.sv
hw/rtl/nhpst_front.sv
hw/rtl/nhpst_queue.sv
hw/rtl/nhpst_log.sv
hw/rtl/nhpst_back.sv
hw/rtl/neo_hookean_plane_strain_tangent_top.sv
test/neo_hookean_plane_strain_tangent_top_test.sv
